@@ src/srb_pkg.sv @@
// shared types, codes and defaults for the stream reassembly buffer
package srb_pkg;

	// default sizes handed to the top-level parameters
	localparam int WINDOW_BYTES_DEF    = 4096;
	localparam int CHUNK_BYTES_MAX_DEF = 8;
	localparam int READ_BYTES_MAX_DEF  = 64;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DROP  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// input item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] chunk_offset;
		logic [3:0]  chunk_length;
		logic [63:0] chunk_bytes;
		logic [6:0]  read_max;
	} srb_in_t;

	// result item
	typedef struct packed {
		logic [31:0] start_offset;
		logic [7:0]  data_byte;
		logic [6:0]  byte_count;
		logic        last;
		logic [12:0] buffered_bytes;
		logic [12:0] available_bytes;
		logic [1:0]  status;
	} srb_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic       wipe_step;
		logic       wipe_finish;
		logic       ins_step;
		logic       scan_start;
		logic       scan_step;
		logic       rd_start;
		logic       rd_emit;
		logic       emit_simple;
		logic [1:0] emit_status;
	} srb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] opcode;
		logic       ins_empty;
		logic       ins_drop;
		logic       ins_last;
		logic       wipe_last;
		logic       scan_done;
		logic       rd_empty;
		logic       rd_last;
		logic       out_free;
	} srb_sts_t;

endpackage

@@ src/stream_reassembly_buffer.sv @@
// top level of the stream reassembly buffer: controller plus datapath
// Rebuilds a byte stream from out-of-order chunks held in a WINDOW_BYTES window.
// After reset the block sweeps all its valid marks before in_ready first rises. An
// insert of L bytes is decoded, written through the single write port of the store,
// and then grows the contiguous run by scanning its valid marks (one mark read per
// cycle) before its result is emitted. A read delivers its bytes one byte per cycle
// from the store read port while the output side keeps up; an empty read or a
// dropped insert yields a single result. A clear sweeps all marks again.
// One item is worked on at a time; results leave through a single output register.
module stream_reassembly_buffer import srb_pkg::*; #(
	parameter int WINDOW_BYTES    = WINDOW_BYTES_DEF,
	parameter int CHUNK_BYTES_MAX = CHUNK_BYTES_MAX_DEF,
	parameter int READ_BYTES_MAX  = READ_BYTES_MAX_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  srb_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output srb_out_t out_data
);

	srb_cmd_t cmd;
	srb_sts_t sts;

	// sequencing
	srb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// storage and arithmetic
	srb_dp #(
		.WINDOW_BYTES    (WINDOW_BYTES),
		.CHUNK_BYTES_MAX (CHUNK_BYTES_MAX),
		.READ_BYTES_MAX  (READ_BYTES_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ src/srb_ctrl.sv @@
// control state machine of the stream reassembly buffer
module srb_ctrl import srb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output srb_cmd_t cmd,
	input  srb_sts_t sts
);

	typedef enum logic [8:0] {
		S_INIT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_DECODE = 9'b000000100,
		S_INS    = 9'b000001000,
		S_SCAN0  = 9'b000010000,
		S_SCAN   = 9'b000100000,
		S_CLR    = 9'b001000000,
		S_RD     = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] st_q, st_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.wipe_step = 1'b1;
				if (sts.wipe_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.opcode)
					OP_INSERT: begin
						if (sts.ins_empty) begin
							st_d    = ST_OK;
							state_d = S_EMIT;
						end else if (sts.ins_drop) begin
							st_d    = ST_DROP;
							state_d = S_EMIT;
						end else begin
							state_d = S_INS;
						end
					end
					OP_READ: begin
						if (sts.rd_empty) begin
							st_d    = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.rd_start = 1'b1;
							state_d      = S_RD;
						end
					end
					OP_CLEAR: begin
						state_d = S_CLR;
					end
					default: begin
						st_d    = ST_OK;
						state_d = S_EMIT;
					end
				endcase
			end
			S_INS: begin
				cmd.ins_step = 1'b1;
				if (sts.ins_last) begin
					state_d = S_SCAN0;
				end
			end
			S_SCAN0: begin
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					st_d    = ST_OK;
					state_d = S_EMIT;
				end
			end
			S_CLR: begin
				cmd.wipe_step = 1'b1;
				if (sts.wipe_last) begin
					cmd.wipe_finish = 1'b1;
					st_d            = ST_OK;
					state_d         = S_EMIT;
				end
			end
			S_RD: begin
				if (sts.out_free) begin
					cmd.rd_emit = 1'b1;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_simple = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.emit_status = st_q;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

@@ src/srb_dp.sv @@
// datapath of the stream reassembly buffer: byte store, valid marks, counters, output register
module srb_dp import srb_pkg::*; #(
	parameter int WINDOW_BYTES    = WINDOW_BYTES_DEF,
	parameter int CHUNK_BYTES_MAX = CHUNK_BYTES_MAX_DEF,
	parameter int READ_BYTES_MAX  = READ_BYTES_MAX_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  srb_in_t  in_data,
	input  srb_cmd_t cmd,
	output srb_sts_t sts,
	output logic     out_valid,
	input  logic     out_ready,
	output srb_out_t out_data
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int CW = $clog2(WINDOW_BYTES + 1);
	localparam logic [32:0]   WIN_EXT = 33'(WINDOW_BYTES);
	localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW_BYTES);

	// byte store and valid marks
	logic [7:0] smem [WINDOW_BYTES];
	logic       vmem [WINDOW_BYTES];
	logic [7:0] srd_q;
	logic       vrd_q;

	// captured item
	logic [1:0]  op_q;
	logic [31:0] coff_q;
	logic [3:0]  len_q;
	logic [63:0] chunk_q;
	logic [6:0]  rmax_q;
	logic [31:0] before_q;

	// window state and step counters
	logic [31:0]   rp_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] contig_q;
	logic [AW-1:0] sweep_q;
	logic [3:0]    k_q;
	logic [6:0]    idx_q;
	logic [6:0]    n_q;

	srb_out_t out_q;
	logic     out_valid_q;

	logic [3:0]    len_in;
	logic [6:0]    rmax_in;
	logic [31:0]   rel;
	logic          drop;
	logic [6:0]    n_sel;
	logic          rd_last;
	logic          scan_go;
	logic [31:0]   ins_rd_ofs;
	logic [31:0]   ins_wr_ofs;
	logic [31:0]   run_ofs;
	logic [31:0]   next_ofs;
	logic [2:0]    bsel;
	logic          load_out;

	logic          v_we, v_wd, v_re;
	logic [AW-1:0] v_wa, v_ra;
	logic          s_we, s_re;
	logic [AW-1:0] s_wa, s_ra;
	logic [7:0]    s_wd;

	// clamping of lengths
	assign len_in  = (in_data.chunk_length > 4'(CHUNK_BYTES_MAX)) ?
		4'(CHUNK_BYTES_MAX) : in_data.chunk_length;
	assign rmax_in = (in_data.read_max > 7'(READ_BYTES_MAX)) ?
		7'(READ_BYTES_MAX) : in_data.read_max;

	// window check and read size
	assign rel     = coff_q - rp_q;
	assign drop    = ({1'b0, rel} + 33'(len_q)) > WIN_EXT;
	assign n_sel   = (contig_q < CW'(rmax_q)) ? contig_q[6:0] : rmax_q;
	assign rd_last = (idx_q + 7'd1) == n_q;
	assign scan_go = vrd_q && (contig_q < WIN_CNT);

	// addresses
	assign ins_rd_ofs = coff_q + 32'(k_q);
	assign ins_wr_ofs = ins_rd_ofs - 32'd1;
	assign run_ofs    = rp_q + 32'(contig_q);
	assign next_ofs   = before_q + 32'(idx_q) + 32'd1;
	assign bsel       = 3'(k_q - 4'd1);

	// memory port selection
	always_comb begin
		v_we = 1'b0;
		v_wd = 1'b0;
		v_wa = '0;
		v_re = 1'b0;
		v_ra = '0;
		s_we = 1'b0;
		s_wa = '0;
		s_wd = chunk_q[{bsel, 3'b000} +: 8];
		s_re = 1'b0;
		s_ra = '0;
		if (cmd.wipe_step) begin
			v_we = 1'b1;
			v_wa = sweep_q;
		end
		if (cmd.ins_step && (k_q != 4'd0)) begin
			v_we = 1'b1;
			v_wd = 1'b1;
			v_wa = ins_wr_ofs[AW-1:0];
			s_we = 1'b1;
			s_wa = ins_wr_ofs[AW-1:0];
		end
		if (cmd.ins_step && (k_q != len_q)) begin
			v_re = 1'b1;
			v_ra = ins_rd_ofs[AW-1:0];
		end
		if (cmd.scan_start) begin
			v_re = 1'b1;
			v_ra = run_ofs[AW-1:0];
		end
		if (cmd.scan_step && scan_go) begin
			v_re = 1'b1;
			v_ra = run_ofs[AW-1:0] + AW'(1);
		end
		if (cmd.rd_start) begin
			v_we = 1'b1;
			v_wa = rp_q[AW-1:0];
			s_re = 1'b1;
			s_ra = rp_q[AW-1:0];
		end
		if (cmd.rd_emit && !rd_last) begin
			v_we = 1'b1;
			v_wa = next_ofs[AW-1:0];
			s_re = 1'b1;
			s_ra = next_ofs[AW-1:0];
		end
	end

	// valid mark memory
	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_wa] <= v_wd;
		end
		if (v_re) begin
			vrd_q <= vmem[v_ra];
		end
	end

	// byte store memory
	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_wa] <= s_wd;
		end
		if (s_re) begin
			srd_q <= smem[s_ra];
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_data.opcode;
			coff_q   <= in_data.chunk_offset;
			len_q    <= len_in;
			chunk_q  <= in_data.chunk_bytes;
			rmax_q   <= rmax_in;
			before_q <= rp_q;
		end
	end

	// window state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			held_q   <= '0;
			contig_q <= '0;
			sweep_q  <= '0;
			k_q      <= '0;
			idx_q    <= '0;
			n_q      <= '0;
		end else begin
			if (cmd.load_in) begin
				k_q <= '0;
			end
			if (cmd.wipe_step) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.wipe_finish) begin
				rp_q     <= '0;
				held_q   <= '0;
				contig_q <= '0;
			end
			if (cmd.ins_step) begin
				k_q <= k_q + 4'd1;
				if ((k_q != 4'd0) && !vrd_q) begin
					held_q <= held_q + CW'(1);
				end
			end
			if (cmd.scan_step && scan_go) begin
				contig_q <= contig_q + CW'(1);
			end
			if (cmd.rd_start) begin
				n_q      <= n_sel;
				idx_q    <= '0;
				rp_q     <= rp_q + 32'(n_sel);
				held_q   <= held_q - CW'(n_sel);
				contig_q <= contig_q - CW'(n_sel);
			end
			if (cmd.rd_emit) begin
				idx_q <= idx_q + 7'd1;
			end
		end
	end

	// output register
	assign load_out = cmd.rd_emit || cmd.emit_simple;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_emit) begin
			out_q.start_offset    <= before_q + 32'(idx_q);
			out_q.data_byte       <= srd_q;
			out_q.byte_count      <= n_q;
			out_q.last            <= rd_last;
			out_q.buffered_bytes  <= 13'(held_q);
			out_q.available_bytes <= 13'(contig_q);
			out_q.status          <= ST_OK;
		end else if (cmd.emit_simple) begin
			out_q.start_offset    <= before_q;
			out_q.data_byte       <= 8'd0;
			out_q.byte_count      <= 7'd0;
			out_q.last            <= 1'b1;
			out_q.buffered_bytes  <= 13'(held_q);
			out_q.available_bytes <= 13'(contig_q);
			out_q.status          <= cmd.emit_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status toward the controller
	assign sts.opcode    = op_q;
	assign sts.ins_empty = (len_q == 4'd0);
	assign sts.ins_drop  = drop;
	assign sts.ins_last  = (k_q == len_q);
	assign sts.wipe_last = (sweep_q == '1);
	assign sts.scan_done = !scan_go;
	assign sts.rd_empty  = (n_sel == 7'd0);
	assign sts.rd_last   = rd_last;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

@@ src/srb_checker.sv @@
// port-level checks of the stream reassembly buffer and their binding
module srb_checker import srb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input srb_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input srb_out_t out_data
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// results that carry no byte are single and zero-filled
	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.byte_count == 7'd0) |->
		out_data.last && (out_data.data_byte == 8'd0))
		else $error("byte-less result not last or not zero");

	// error results deliver nothing
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> (out_data.byte_count == 7'd0))
		else $error("error result with a byte count");

	// no new item while a multi-byte read is still delivering
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("input taken in the middle of a read");

endmodule

bind stream_reassembly_buffer srb_checker u_srb_checker (.*);
